// File: hw/rtl/i2cmra_pkg.sv
package i2cmra_pkg;

  localparam int unsigned FifoDepthDefault = 16;

  localparam logic [7:0] MsbMask = 8'h80;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_BEGIN = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_PROBE = 2'd2,
    OP_OTHER = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_DEV   = 2'd1,
    ST_REG_NACK = 2'd2,
    ST_DAT_NACK = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START   = 4'd1,
    PH_ADDR_W  = 4'd2,
    PH_REG     = 4'd3,
    PH_RESTART = 4'd4,
    PH_ADDR_R  = 4'd5,
    PH_READ    = 4'd6,
    PH_WAIT    = 4'd7,
    PH_WDATA   = 4'd8,
    PH_STOP    = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    SEQ_START   = 2'd0,
    SEQ_RESTART = 2'd1,
    SEQ_STOP    = 2'd2
  } seq_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_SCL_LOW = 3'd1,
    ACT_SCL_REL = 3'd2,
    ACT_SDA_LOW = 3'd3,
    ACT_SDA_REL = 3'd4
  } act_e;

  // result word, scl_drive in the lowest bit
  typedef struct packed {
    logic          fifo_full;
    logic          busy_res;
    logic [1:0]    status;
    logic          done_res;
    logic          rx_valid;
    logic [7:0]    rx_byte;
    logic          sda_drive;
    logic          scl_drive;
  } res_t;

  typedef struct packed {
    logic rx_last;
    res_t res;
  } out_word_t;

  function automatic act_e seq_act(input seq_e kind, input logic [2:0] step);
    act_e act;
    act = ACT_NONE;
    case (kind)
      SEQ_START: begin
        case (step)
          3'd0: act = ACT_SCL_LOW;
          3'd1: act = ACT_SDA_REL;
          3'd2: act = ACT_SCL_REL;
          3'd3: act = ACT_SDA_LOW;
          default: act = ACT_NONE;
        endcase
      end
      SEQ_RESTART: begin
        case (step)
          3'd0: act = ACT_SCL_LOW;
          3'd1: act = ACT_SDA_LOW;
          3'd2: act = ACT_SCL_REL;
          3'd3: act = ACT_SDA_REL;
          3'd5: act = ACT_SDA_LOW;
          default: act = ACT_NONE;
        endcase
      end
      default: begin
        case (step)
          3'd0: act = ACT_SCL_LOW;
          3'd1: act = ACT_SDA_LOW;
          3'd2: act = ACT_SCL_REL;
          3'd3: act = ACT_SDA_REL;
          default: act = ACT_NONE;
        endcase
      end
    endcase
    return act;
  endfunction

  function automatic logic [2:0] seq_len(input seq_e kind);
    logic [2:0] len;
    case (kind)
      SEQ_RESTART: len = 3'd7;
      default:     len = 3'd5;
    endcase
    return len;
  endfunction

endpackage

// File: hw/rtl/i2c_master_register_access.sv
// a result word is registered in the output register, or in the skid stage while the output register is held
// throughput: one word per cycle while the skid stage is empty, each tick, load or begin handled in a single pass
// a skid stage keeps the slave side ready while one finished word waits downstream
// the write fifo is a memory with a registered read and a bypass for a fresh write
// reset: idle, both lines released, fifo empty, no word pending, no clearing pass
module i2c_master_register_access #(
  parameter int unsigned FifoDepth = i2cmra_pkg::FifoDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // sda_in, scl_in, data_byte, slave_address, mem_address, op, length, zero fill
  input  logic [47:0]            s_axis_tdata,
  // func
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // scl_drive, sda_drive, rx_byte, rx_valid, done_res, status, busy_res, fifo_full
  output logic [15:0]            m_axis_tdata,
  // rx_last
  output logic                   m_axis_tlast
);
  import i2cmra_pkg::*;

  localparam int unsigned CntW = $clog2(FifoDepth + 1);
  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;

  // input word fields
  logic        sda_in, scl_in;
  logic [7:0]  data_byte, mem_address;
  logic [6:0]  slave_address;
  logic [1:0]  op;
  logic [15:0] length;
  func_e       func;

  assign sda_in        = s_axis_tdata[0];
  assign scl_in        = s_axis_tdata[1];
  assign data_byte     = s_axis_tdata[9:2];
  assign slave_address = s_axis_tdata[16:10];
  assign mem_address   = s_axis_tdata[24:17];
  assign op            = s_axis_tdata[26:25];
  assign length        = s_axis_tdata[42:27];
  assign func          = func_e'(s_axis_tuser);

  // transaction state
  phase_e      phase_q, phase_d;
  logic [2:0]  step_q, step_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [6:0]  dev_addr_q, dev_addr_d;
  logic [7:0]  reg_addr_q, reg_addr_d;
  op_e         op_kind_q, op_kind_d;
  logic        scl_q, scl_d, sda_q, sda_d;

  // write fifo
  logic [7:0]      fifo_mem [FifoDepth];
  logic [CntW-1:0] fifo_cnt_q, fifo_cnt_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d, rd_ptr_nxt, wr_ptr_q, wr_ptr_d;
  logic [7:0]      rd_data_q, byp_data_q, fifo_head;
  logic            byp_q, fifo_wr;

  // output queue
  out_word_t res, out_q, skid_q;
  logic      out_vld_q, skid_vld_q;
  logic      acc, take;

  assign s_axis_tready = ~skid_vld_q;
  assign acc           = s_axis_tvalid & s_axis_tready;
  assign take          = out_vld_q & m_axis_tready;
  assign fifo_head     = byp_q ? byp_data_q : rd_data_q;

  always_comb begin
    logic       reading, receiving, sample, nack, done;
    logic [1:0] st;
    seq_e       kind;
    act_e       act;
    logic [2:0] s;

    phase_d      = phase_q;
    step_d       = step_q;
    bit_cnt_d    = bit_cnt_q;
    shift_d      = shift_q;
    bytes_left_d = bytes_left_q;
    dev_addr_d   = dev_addr_q;
    reg_addr_d   = reg_addr_q;
    op_kind_d    = op_kind_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    fifo_cnt_d   = fifo_cnt_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    fifo_wr      = 1'b0;
    res          = '0;
    reading      = 1'b0;
    receiving    = 1'b0;
    sample       = 1'b0;
    nack         = 1'b0;
    done         = 1'b0;
    st           = ST_OK;
    kind         = SEQ_STOP;
    act          = ACT_NONE;
    s            = 3'd0;

    case (func)
      FUNC_TICK: begin
        if (phase_d == PH_WAIT && fifo_cnt_q != '0) begin
          phase_d    = PH_WDATA;
          bit_cnt_d  = 4'd0;
          step_d     = 3'd0;
          shift_d    = fifo_head;
          rd_ptr_d   = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
          fifo_cnt_d = fifo_cnt_q - 1'b1;
        end
        if (phase_d == PH_START || phase_d == PH_RESTART || phase_d == PH_STOP) begin
          kind = (phase_d == PH_START)   ? SEQ_START :
                 (phase_d == PH_RESTART) ? SEQ_RESTART : SEQ_STOP;
          s    = step_d;
          act  = seq_act(kind, s);
          case (act)
            ACT_SCL_LOW: scl_d = 1'b0;
            ACT_SCL_REL: scl_d = 1'b1;
            ACT_SDA_LOW: sda_d = 1'b0;
            ACT_SDA_REL: sda_d = 1'b1;
            default: ;
          endcase
          step_d = s + 3'd1;
          if (step_d >= seq_len(kind)) begin
            step_d = 3'd0;
            case (kind)
              SEQ_START: begin
                phase_d   = PH_ADDR_W;
                bit_cnt_d = 4'd0;
                shift_d   = {dev_addr_q, 1'b0};
              end
              SEQ_RESTART: begin
                phase_d   = PH_ADDR_R;
                bit_cnt_d = 4'd0;
                shift_d   = {dev_addr_q, 1'b1};
              end
              default: begin
                done = 1'b1;
                st   = ST_OK;
              end
            endcase
          end
        end else if (phase_d != PH_IDLE && phase_d != PH_WAIT) begin
          reading   = (phase_d == PH_READ);
          receiving = reading ? (bit_cnt_d < 4'd8) : (bit_cnt_d == 4'd8);
          case (step_d[1:0])
            2'd0: begin
              scl_d  = 1'b0;
              step_d = 3'd1;
            end
            2'd1: begin
              if (receiving) sda_d = 1'b1;
              else if (reading) sda_d = (bytes_left_d <= 16'd1);
              else sda_d = |(shift_d & MsbMask);
              step_d = 3'd2;
            end
            2'd2: begin
              scl_d  = 1'b1;
              step_d = 3'd3;
            end
            default: begin
              // hold while the slave stretches the clock
              if (!(receiving && !scl_in)) begin
                sample = receiving & sda_in;
                nack   = sample;
                step_d = 3'd0;
                if (bit_cnt_d < 4'd8) begin
                  shift_d   = {shift_d[6:0], reading & sample};
                  bit_cnt_d = bit_cnt_d + 4'd1;
                end else begin
                  case (phase_d)
                    PH_ADDR_W: begin
                      if (nack) begin
                        done = 1'b1;
                        st   = ST_NO_DEV;
                      end else if (op_kind_q == OP_READ || op_kind_q == OP_WRITE) begin
                        phase_d   = PH_REG;
                        bit_cnt_d = 4'd0;
                        shift_d   = reg_addr_q;
                      end else begin
                        phase_d = PH_STOP;
                      end
                    end
                    PH_REG: begin
                      if (nack) begin
                        done = 1'b1;
                        st   = ST_REG_NACK;
                      end else if (op_kind_q == OP_READ) begin
                        phase_d = PH_RESTART;
                      end else begin
                        phase_d = (bytes_left_d == '0) ? PH_STOP : PH_WAIT;
                      end
                    end
                    PH_ADDR_R: begin
                      if (nack) begin
                        done = 1'b1;
                        st   = ST_NO_DEV;
                      end else begin
                        phase_d   = PH_READ;
                        bit_cnt_d = 4'd0;
                        shift_d   = 8'd0;
                      end
                    end
                    PH_WDATA: begin
                      if (nack) begin
                        done = 1'b1;
                        st   = ST_DAT_NACK;
                      end else begin
                        bytes_left_d = bytes_left_d - 16'd1;
                        phase_d = (bytes_left_d == '0) ? PH_STOP : PH_WAIT;
                      end
                    end
                    default: begin
                      res.res.rx_valid = 1'b1;
                      res.res.rx_byte  = shift_d;
                      res.rx_last      = (bytes_left_d <= 16'd1);
                      bytes_left_d     = bytes_left_d - 16'd1;
                      if (bytes_left_d == '0) begin
                        phase_d = PH_STOP;
                      end else begin
                        phase_d   = PH_READ;
                        bit_cnt_d = 4'd0;
                        shift_d   = 8'd0;
                      end
                    end
                  endcase
                end
              end
            end
          endcase
        end
        if (done) begin
          phase_d   = PH_IDLE;
          step_d    = 3'd0;
          bit_cnt_d = 4'd0;
        end
      end
      FUNC_LOAD: begin
        if (fifo_cnt_q < CntW'(FifoDepth)) begin
          fifo_wr    = 1'b1;
          fifo_cnt_d = fifo_cnt_q + 1'b1;
          wr_ptr_d   = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
        end
      end
      FUNC_BEGIN: begin
        if (phase_q == PH_IDLE) begin
          dev_addr_d   = slave_address;
          reg_addr_d   = mem_address;
          op_kind_d    = (op == OP_OTHER) ? OP_PROBE : op_e'(op);
          bytes_left_d = (op == OP_READ && length == '0) ? 16'd1 : length;
          bit_cnt_d    = 4'd0;
          step_d       = 3'd0;
          phase_d      = PH_START;
        end
      end
      default: ;
    endcase

    res.res.scl_drive = scl_d;
    res.res.sda_drive = sda_d;
    res.res.done_res  = done;
    res.res.status    = st;
    res.res.busy_res  = (phase_d != PH_IDLE);
    res.res.fifo_full = (fifo_cnt_d >= CntW'(FifoDepth));
  end

  assign rd_ptr_nxt = acc ? rd_ptr_d : rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      step_q       <= '0;
      bit_cnt_q    <= '0;
      shift_q      <= '0;
      bytes_left_q <= '0;
      dev_addr_q   <= '0;
      reg_addr_q   <= '0;
      op_kind_q    <= OP_READ;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      fifo_cnt_q   <= '0;
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      byp_q        <= 1'b0;
    end else begin
      if (acc) begin
        phase_q      <= phase_d;
        step_q       <= step_d;
        bit_cnt_q    <= bit_cnt_d;
        shift_q      <= shift_d;
        bytes_left_q <= bytes_left_d;
        dev_addr_q   <= dev_addr_d;
        reg_addr_q   <= reg_addr_d;
        op_kind_q    <= op_kind_d;
        scl_q        <= scl_d;
        sda_q        <= sda_d;
        fifo_cnt_q   <= fifo_cnt_d;
        rd_ptr_q     <= rd_ptr_d;
        wr_ptr_q     <= wr_ptr_d;
      end
      byp_q <= acc & fifo_wr & (wr_ptr_q == rd_ptr_nxt);
    end
  end

  // fifo memory with registered read of the next head entry
  always_ff @(posedge clk_i) begin
    if (acc && fifo_wr) begin
      fifo_mem[wr_ptr_q] <= data_byte;
    end
    rd_data_q  <= fifo_mem[rd_ptr_nxt];
    byp_data_q <= data_byte;
  end

  // output register plus skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || take) begin
        if (skid_vld_q) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end else begin
          out_vld_q <= acc;
        end
      end else if (acc) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || take) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (acc) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q.res;
  assign m_axis_tlast  = out_q.rx_last;

  a_fifo_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= CntW'(FifoDepth))
    else $error("fifo count above depth");

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid word held with empty output register");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.res.done_res) |-> !out_q.res.busy_res)
    else $error("finished transaction still busy");

  a_status_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.res.status != ST_OK) |-> out_q.res.done_res)
    else $error("status without done");

  a_last_needs_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.rx_last) |-> out_q.res.rx_valid)
    else $error("last flag without received byte");

  a_idle_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (step_q == 3'd0 && bit_cnt_q == 4'd0))
    else $error("idle with slot counters not cleared");

endmodule
